// File: src/cte_pkg.sv
// Shared constants, codes and types of the CLUT texel expander.
`default_nettype none

package cte_pkg;

    localparam int SLOT_W   = 8;
    localparam int WORD_W   = 16;
    localparam int FIRST_W  = 2;
    localparam int COUNT_W  = 3;
    localparam int PIXEL_W  = 32;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;

    // Commands carried by an input item.
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_EXPAND  = 1'b1;

    // Colour depth modes; the unused fourth code behaves as direct colour.
    localparam logic [MODE_W-1:0] MODE_4BIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_8BIT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd2;

    localparam logic [MODE_W-1:0] TRANS_HALF = 2'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_MODE = 1'b1;

    // Request presented to every lane at the edge an item is accepted.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic [MODE_W-1:0] depth_mode;
    } lane_req_t;

    // Item information held alongside the lanes' palette read registers.
    typedef struct packed {
        logic              direct;
        logic [WORD_W-1:0] word;
        logic [MODE_W-1:0] trans_mode;
    } lane_stage_t;

endpackage

`default_nettype wire

// File: src/cte_if.sv
// Handshake channels of the CLUT texel expander: texel input, pixel output, configuration.
`default_nettype none

interface cte_texel_if;
    import cte_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [SLOT_W-1:0]  palette_slot;
    logic [WORD_W-1:0]  source_word;
    logic [FIRST_W-1:0] first_texel;
    logic [COUNT_W-1:0] texel_count;

    modport source (
        output valid, command, palette_slot, source_word, first_texel, texel_count,
        input  ready
    );
    modport sink (
        input  valid, command, palette_slot, source_word, first_texel, texel_count,
        output ready
    );
endinterface

interface cte_pixel_if;
    import cte_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_zero;
    logic [PIXEL_W-1:0] pixel_one;
    logic [PIXEL_W-1:0] pixel_two;
    logic [PIXEL_W-1:0] pixel_three;
    logic [COUNT_W-1:0] pixel_count;

    modport source (
        output valid, pixel_zero, pixel_one, pixel_two, pixel_three, pixel_count,
        input  ready
    );
    modport sink (
        input  valid, pixel_zero, pixel_one, pixel_two, pixel_three, pixel_count,
        output ready
    );
endinterface

interface cte_cfg_if;
    import cte_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MODE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/cte_lane.sv
// One expansion lane: texel index selection, a private palette copy and colour expansion.
`default_nettype none

module cte_lane #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cte_pkg::lane_req_t          req,
    input  wire logic [cte_pkg::FIRST_W-1:0] texel,
    input  wire logic                        active,
    input  wire cte_pkg::lane_stage_t        stage,
    output logic      [cte_pkg::PIXEL_W-1:0] pixel
);
    import cte_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int SLOTS = 1 << SLOT_W;

    // Reduction of an 8-bit index into the palette depth.
    function automatic logic [SLOTS*AW-1:0] build_mod_table();
        logic [SLOTS*AW-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl[i*AW +: AW] = AW'(i % PALETTE_DEPTH);
        end
        return tbl;
    endfunction

    // Five-bit channel to eight bits, rounded: (c * 510 + 31) / 62.
    function automatic logic [32*8-1:0] build_chan_lut();
        logic [32*8-1:0] lut;
        lut = '0;
        for (int c = 0; c < 32; c++) begin
            lut[c*8 +: 8] = 8'((c * 510 + 31) / 62);
        end
        return lut;
    endfunction

    localparam logic [SLOTS*AW-1:0] MOD_TABLE = build_mod_table();
    localparam logic [32*8-1:0]     CHAN_LUT  = build_chan_lut();

    logic [WORD_W-1:0] mem [PALETTE_DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic              active_reg;
    logic [SLOT_W-1:0] index;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] raw;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;

    always_comb
    begin
        unique case (req.depth_mode)
            MODE_4BIT:
            begin
                index = {4'h0, 4'(req.word >> {texel, 2'b00})};
            end
            MODE_8BIT:
            begin
                index = texel[0] ? req.word[15:8] : req.word[7:0];
            end
            default:
            begin
                index = '0;
            end
        endcase
    end

    assign rd_addr = MOD_TABLE[index*AW +: AW];
    assign wr_addr = MOD_TABLE[req.slot*AW +: AW];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= req.word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (req.rd_en)
        begin
            active_reg <= active;
        end
    end

    assign raw   = stage.direct ? stage.word : rdata_reg;
    assign red   = CHAN_LUT[raw[4:0]*8 +: 8];
    assign green = CHAN_LUT[raw[9:5]*8 +: 8];
    assign blue  = CHAN_LUT[raw[14:10]*8 +: 8];

    always_comb
    begin
        if (raw[15])
        begin
            alpha = (stage.trans_mode == TRANS_HALF) ? 8'h7F : 8'hFF;
        end
        else
        begin
            alpha = ((red | green | blue) == 8'h00) ? 8'h00 : 8'hFF;
        end
    end

    // Lanes beyond the item's count give zero.
    assign pixel = active_reg ? {alpha, blue, green, red} : '0;

endmodule

`default_nettype wire

// File: src/clut_texel_expander.sv
// Top level of the CLUT texel expander: control, lanes, and the merging output register.
`default_nettype none

// The expander takes one item per clock and, while the output is not stalled, keeps
// a sustained rate of one item per cycle; an item passes the lanes' read registers
// and then the output register. Palette write items take one item slot each and
// give no result. Every lane holds its own copy of the palette in a memory with
// one write and one read port, so all lanes of a word look up their colours in
// the same cycle; a palette write updates every copy at once. The read stage
// selects each lane's index and reads its palette copy into a register, the
// expand step then expands the colours and merges the lanes into the output
// register, which holds a result while the next item is already being taken in.
// The palette needs no clearing pass after reset: an entry must be written before
// a texel refers to it. Configuration writes are taken at any time and must only
// be issued while no item is in flight.
module clut_texel_expander #(
    parameter int PALETTE_DEPTH = 256,
    parameter int LANE_COUNT    = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cte_texel_if.sink   texels,
    cte_pixel_if.source pixels,
    cte_cfg_if.sink     cfg
);
    import cte_pkg::*;

    localparam logic [COUNT_W-1:0] LANE_MAX = COUNT_W'(LANE_COUNT);

    logic [MODE_W-1:0]  depth_mode_reg;
    logic [MODE_W-1:0]  trans_mode_reg;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [COUNT_W-1:0] s1_count_reg;
    logic               s1_direct_reg;
    logic [WORD_W-1:0]  s1_word_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [PIXEL_W-1:0] out_pix_reg [LANE_COUNT];

    logic               accept;
    logic               move;
    logic               produce;
    logic               direct;
    logic [COUNT_W-1:0] per_word;
    logic [COUNT_W-1:0] first_ext;
    logic [COUNT_W-1:0] left;
    logic [COUNT_W-1:0] cnt_left;
    logic [COUNT_W-1:0] cnt;

    lane_req_t          req;
    lane_stage_t        stage;
    logic [FIRST_W-1:0] lane_texel  [LANE_COUNT];
    logic               lane_active [LANE_COUNT];
    logic [PIXEL_W-1:0] lane_pixel  [LANE_COUNT];

    // Configuration registers; the port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= MODE_4BIT;
            trans_mode_reg <= TRANS_HALF;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DEPTH_MODE: depth_mode_reg <= cfg.data;
                CFG_TRANS_MODE: trans_mode_reg <= cfg.data;
                default:        depth_mode_reg <= depth_mode_reg;
            endcase
        end
    end

    // Handshake: the read stage moves on when the output register is free or
    // being emptied, and a new item enters when the read stage is empty or moving on.
    assign move         = s1_valid_reg && (!out_valid_reg || pixels.ready);
    assign texels.ready = !s1_valid_reg || move;
    assign accept       = texels.valid && texels.ready;

    // Texels in the word, clamped by what is left after the first texel and by
    // the number of lanes; zero when the first texel lies beyond the word.
    always_comb
    begin
        unique case (depth_mode_reg)
            MODE_4BIT: per_word = 3'd4;
            MODE_8BIT: per_word = 3'd2;
            default:   per_word = 3'd1;
        endcase
        first_ext = {1'b0, texels.first_texel};
        left      = per_word - first_ext;
        cnt_left  = (texels.texel_count < left) ? texels.texel_count : left;
        if (first_ext >= per_word)
        begin
            cnt = '0;
        end
        else
        begin
            cnt = (cnt_left < LANE_MAX) ? cnt_left : LANE_MAX;
        end
    end

    assign direct  = (depth_mode_reg != MODE_4BIT) && (depth_mode_reg != MODE_8BIT);
    assign produce = (texels.command == CMD_EXPAND) && (cnt != '0);

    assign req.wr_en      = accept && (texels.command == CMD_PALETTE);
    assign req.rd_en      = accept;
    assign req.slot       = texels.palette_slot;
    assign req.word       = texels.source_word;
    assign req.depth_mode = depth_mode_reg;

    assign stage.direct     = s1_direct_reg;
    assign stage.word       = s1_word_reg;
    assign stage.trans_mode = trans_mode_reg;

    genvar k;
    generate
        for (k = 0; k < LANE_COUNT; k++)
        begin : g_lane
            assign lane_texel[k]  = texels.first_texel + FIRST_W'(k);
            assign lane_active[k] = COUNT_W'(k) < cnt;

            cte_lane #(
                .PALETTE_DEPTH (PALETTE_DEPTH)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .req    (req),
                .texel  (lane_texel[k]),
                .active (lane_active[k]),
                .stage  (stage),
                .pixel  (lane_pixel[k])
            );
        end
    endgenerate

    // Read stage bookkeeping.
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = produce;
        end
        else if (move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_count_reg  <= cnt;
            s1_direct_reg <= direct;
            s1_word_reg   <= texels.source_word;
        end
    end

    // Merging output register.
    always_comb
    begin
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_count_reg <= s1_count_reg;
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                out_pix_reg[i] <= lane_pixel[i];
            end
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_count = out_count_reg;
    assign pixels.pixel_zero  = out_pix_reg[0];

    generate
        if (LANE_COUNT > 1)
        begin : g_pix_one
            assign pixels.pixel_one = out_pix_reg[1];
        end
        else
        begin : g_pix_one_zero
            assign pixels.pixel_one = '0;
        end
        if (LANE_COUNT > 2)
        begin : g_pix_two
            assign pixels.pixel_two = out_pix_reg[2];
        end
        else
        begin : g_pix_two_zero
            assign pixels.pixel_two = '0;
        end
        if (LANE_COUNT > 3)
        begin : g_pix_three
            assign pixels.pixel_three = out_pix_reg[3];
        end
        else
        begin : g_pix_three_zero
            assign pixels.pixel_three = '0;
        end
    endgenerate

`ifndef SYNTHESIS
    // A result always carries between one pixel and one pixel per lane.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg != '0) && (out_count_reg <= LANE_MAX))
        else $error("pixel count out of range");

    // An item in the read stage is never dropped while the output is stalled.
    a_read_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !pixels.ready) |=> s1_valid_reg)
        else $error("read stage item lost under stall");

    // A single-pixel result leaves the second pixel field zero.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_count_reg == 3'd1)) |-> (pixels.pixel_one == '0))
        else $error("unused pixel field not zero");
`endif

endmodule

`default_nettype wire
